FILE: rtl/core/i2crtm_pkg.sv
// Shared types and constants for the I2C register transaction master.
`default_nettype none
package i2crtm_pkg;

    // Default depth of the write byte buffer.
    localparam int unsigned MAX_BYTES_DEF = 16;

    // Reset values of the configuration registers.
    localparam logic [7:0] RETRY_LIMIT_RST = 8'd20;
    localparam logic [7:0] PHASE_TICKS_RST = 8'd1;

    // Request codes.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_PUSH  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Configuration register indexes.
    localparam logic REG_RETRY_LIMIT = 1'b0;
    localparam logic REG_PHASE_TICKS = 1'b1;

    // One request as it travels from the front part to the sequencer.
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [4:0] byte_count;
        logic [7:0] wr_data;
        logic       sda_in;
    } item_t;

    // One result.
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       rd_valid;
        logic [7:0] rd_data;
        logic       rd_last;
        logic       done_res;
        logic       status;
    } res_t;

    // Settings handed to the sequencer.
    typedef struct packed {
        logic [7:0] retry_limit;
        logic [7:0] phase_ticks;
    } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/i2c_register_transaction_master.sv
// Top level of the I2C register transaction master with its register port.
//
// Requests enter on in_valid/in_ready; each request gives exactly one result
// on out_valid/out_ready. Request kinds: tick, push a write byte, start a
// write transaction, start a read transaction. After a start, only ticks
// move the bus; a bus phase lasts phase_ticks ticks (0 acts as 1). scl_out
// and sda_out are open-drain drives (1 releases the line).
// A request is taken into a two-entry queue, and the sequencer handles one
// request per clock, so one request per cycle is sustained while the
// receiver is ready. A result passes the queue stage, then the result
// register. When the receiver stalls, the result register holds and the
// queue fills; in_ready drops once both queue entries are occupied.
// Reset returns the sequencer to idle with both lines released, the
// settings to retry_limit 20 and phase_ticks 1. The write buffer content is
// undefined until bytes are pushed.
// Settings: register 0 retry_limit at address 0, register 1 phase_ticks at
// address 4; write them only while no transaction is running.
`default_nettype none
module i2c_register_transaction_master #(
    parameter int unsigned MAX_BYTES = i2crtm_pkg::MAX_BYTES_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  req_type,
    input  wire  [7:0]  dev_addr,
    input  wire  [7:0]  reg_addr,
    input  wire  [4:0]  byte_count,
    input  wire  [7:0]  wr_data,
    input  wire         sda_in,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        scl_out,
    output logic        sda_out,
    output logic        busy_res,
    output logic        rd_valid,
    output logic [7:0]  rd_data,
    output logic        rd_last,
    output logic        done_res,
    output logic        status,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2crtm_pkg::*;

    item_t      in_item;
    item_t      q_item;
    res_t       res;
    cfg_t       cfg;
    logic       q_valid;
    logic       q_pop;
    logic [7:0] retry_limit_reg;
    logic [7:0] phase_ticks_reg;
    logic       cfg_we;

    // Register port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RST;
            phase_ticks_reg <= PHASE_TICKS_RST;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_RETRY_LIMIT && paddr[1:0] == 2'd0)
            begin
                retry_limit_reg <= pwdata[7:0];
            end
            else if (paddr[2] == REG_PHASE_TICKS && paddr[1:0] == 2'd0)
            begin
                phase_ticks_reg <= pwdata[7:0];
            end
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_RETRY_LIMIT)
        begin
            prdata = {24'd0, retry_limit_reg};
        end
        else
        begin
            prdata = {24'd0, phase_ticks_reg};
        end
    end

    assign cfg.retry_limit = retry_limit_reg;
    assign cfg.phase_ticks = phase_ticks_reg;

    // Request payload packing.
    assign in_item.req_type   = req_type;
    assign in_item.dev_addr   = dev_addr;
    assign in_item.reg_addr   = reg_addr;
    assign in_item.byte_count = byte_count;
    assign in_item.wr_data    = wr_data;
    assign in_item.sda_in     = sda_in;

    i2crtm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    i2crtm_seq #(
        .MAX_BYTES (MAX_BYTES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    // Result fields.
    assign scl_out  = res.scl_out;
    assign sda_out  = res.sda_out;
    assign busy_res = res.busy_res;
    assign rd_valid = res.rd_valid;
    assign rd_data  = res.rd_data;
    assign rd_last  = res.rd_last;
    assign done_res = res.done_res;
    assign status   = res.status;

endmodule
`default_nettype wire

FILE: rtl/core/i2crtm_front.sv
// Front part: accepts requests into a two-entry queue for the sequencer.
`default_nettype none
module i2crtm_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  i2crtm_pkg::item_t in_item,
    output logic                q_valid,
    input  wire                 q_pop,
    output i2crtm_pkg::item_t   q_item
);
    import i2crtm_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    // Handshake decode.
    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/i2crtm_seq.sv
// Back part: bus sequencer, write byte buffer and result register.
`default_nettype none
module i2crtm_seq #(
    parameter int unsigned MAX_BYTES = i2crtm_pkg::MAX_BYTES_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire  i2crtm_pkg::cfg_t  cfg,
    input  wire                 q_valid,
    output logic                q_pop,
    input  wire  i2crtm_pkg::item_t q_item,
    output logic                out_valid,
    input  wire                 out_ready,
    output i2crtm_pkg::res_t    out_res
);
    import i2crtm_pkg::*;

    localparam int unsigned IW0  = $clog2(MAX_BYTES + 1);
    localparam int unsigned IDXW = (IW0 > 5) ? IW0 : 5;
    localparam int unsigned AW   = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam logic [IDXW:0] MAXV = (IDXW + 1)'(MAX_BYTES);

    // Sequencer states.
    localparam logic [3:0] M_IDLE = 4'd0;
    localparam logic [3:0] M_STOP = 4'd1;
    localparam logic [3:0] M_S1   = 4'd2;
    localparam logic [3:0] M_S2   = 4'd3;
    localparam logic [3:0] M_S3   = 4'd4;
    localparam logic [3:0] M_B1   = 4'd5;
    localparam logic [3:0] M_B2   = 4'd6;
    localparam logic [3:0] M_B3   = 4'd7;
    localparam logic [3:0] M_A1   = 4'd8;
    localparam logic [3:0] M_A2   = 4'd9;
    localparam logic [3:0] M_A3   = 4'd10;
    localparam logic [3:0] M_R1   = 4'd11;
    localparam logic [3:0] M_R2   = 4'd12;
    localparam logic [3:0] M_K1   = 4'd13;
    localparam logic [3:0] M_K2   = 4'd14;
    localparam logic [3:0] M_K3   = 4'd15;

    // Transaction steps.
    localparam logic [3:0] T_PRESTOP = 4'd0;
    localparam logic [3:0] T_WDEV    = 4'd1;
    localparam logic [3:0] T_WREG    = 4'd2;
    localparam logic [3:0] T_WDATA   = 4'd3;
    localparam logic [3:0] T_RDEV    = 4'd4;
    localparam logic [3:0] T_RREG    = 4'd5;
    localparam logic [3:0] T_MIDSTOP = 4'd6;
    localparam logic [3:0] T_RDEV1   = 4'd7;
    localparam logic [3:0] T_RDATA   = 4'd8;
    localparam logic [3:0] T_FINAL   = 4'd9;

    // Bus actions that open a new sequencer state.
    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_STOP  = 3'd1;
    localparam logic [2:0] ACT_START = 3'd2;
    localparam logic [2:0] ACT_SEND  = 3'd3;
    localparam logic [2:0] ACT_RBYTE = 3'd4;
    localparam logic [2:0] ACT_RBIT  = 3'd5;

    logic [3:0]      st_reg, st_next;
    logic [7:0]      pc_reg, pc_next;
    logic [3:0]      bc_reg, bc_next;
    logic [7:0]      sb_reg, sb_next;
    logic [IDXW-1:0] bi_reg, bi_next;
    logic [7:0]      ac_reg, ac_next;
    logic            scl_reg, scl_next;
    logic            sda_reg, sda_next;
    logic [3:0]      step_reg, step_next;
    logic [7:0]      dev_reg, dev_next;
    logic [7:0]      rg_reg, rg_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            fst_reg, fst_next;
    logic            ack_reg, ack_next;
    logic [7:0]      buf_mem [MAX_BYTES];
    logic            out_valid_reg;
    res_t            out_res_reg;
    res_t            res_next;

    logic            take;
    logic            buf_we;
    logic [AW-1:0]   buf_wa;
    logic [2:0]      act;
    logic [7:0]      send_byte;
    logic [7:0]      limit;
    logic [7:0]      pc_t;
    logic [3:0]      bc_t;
    logic [IDXW:0]   bi_t;
    logic [IDXW:0]   rd_cnt;
    logic            is_last;
    logic [7:0]      ac_t;
    logic            ev_rd;
    logic            ev_last;
    logic            ev_done;
    logic [7:0]      ev_data;
    logic            ev_status;

    // One request is taken whenever the result register can hold its result.
    assign take      = q_valid && (!out_valid_reg || out_ready);
    assign q_pop     = take;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign limit   = (cfg.phase_ticks == 8'd0) ? 8'd1 : cfg.phase_ticks;
    assign rd_cnt  = (cnt_reg == 5'd0) ? (IDXW + 1)'(1) : (IDXW + 1)'(cnt_reg);
    assign is_last = ({1'b0, bi_reg} + (IDXW + 1)'(1)) >= rd_cnt;

    // Sequencer next state for one request.
    always_comb
    begin
        st_next   = st_reg;
        pc_next   = pc_reg;
        bc_next   = bc_reg;
        sb_next   = sb_reg;
        bi_next   = bi_reg;
        ac_next   = ac_reg;
        scl_next  = scl_reg;
        sda_next  = sda_reg;
        step_next = step_reg;
        dev_next  = dev_reg;
        rg_next   = rg_reg;
        cnt_next  = cnt_reg;
        fst_next  = fst_reg;
        ack_next  = ack_reg;
        buf_we    = 1'b0;
        buf_wa    = bi_reg[AW-1:0];
        act       = ACT_NONE;
        send_byte = 8'd0;
        pc_t      = pc_reg + 8'd1;
        bc_t      = bc_reg + 4'd1;
        bi_t      = {1'b0, bi_reg} + (IDXW + 1)'(1);
        ac_t      = ac_reg + 8'd1;
        ev_rd     = 1'b0;
        ev_last   = 1'b0;
        ev_done   = 1'b0;
        ev_data   = 8'd0;
        ev_status = 1'b0;

        if (st_reg == M_IDLE)
        begin
            // Idle: buffer pushes and transaction starts.
            if (q_item.req_type == REQ_PUSH)
            begin
                if ({1'b0, bi_reg} < MAXV)
                begin
                    buf_we  = 1'b1;
                    bi_next = bi_t[IDXW-1:0];
                end
            end
            else if (q_item.req_type == REQ_WRITE || q_item.req_type == REQ_READ)
            begin
                dev_next = q_item.dev_addr;
                rg_next  = q_item.reg_addr;
                cnt_next = q_item.byte_count;
                bi_next  = '0;
                ac_next  = 8'd0;
                fst_next = 1'b0;
                if (q_item.req_type == REQ_WRITE)
                begin
                    step_next = T_PRESTOP;
                    act       = ACT_STOP;
                end
                else
                begin
                    step_next = T_RDEV;
                    act       = ACT_START;
                end
            end
        end
        else if (q_item.req_type == REQ_TICK)
        begin
            if (pc_t < limit)
            begin
                pc_next = pc_t;
            end
            else
            begin
                pc_next = 8'd0;
                // Advance the bus by one phase.
                unique case (st_reg)
                    M_STOP:
                    begin
                        sda_next = 1'b1;
                        if (step_reg == T_PRESTOP)
                        begin
                            step_next = T_WDEV;
                            act       = ACT_START;
                        end
                        else if (step_reg == T_MIDSTOP)
                        begin
                            step_next = T_RDEV1;
                            ac_next   = 8'd0;
                            act       = ACT_START;
                        end
                        else
                        begin
                            st_next   = M_IDLE;
                            ev_done   = 1'b1;
                            ev_status = fst_reg;
                            bi_next   = '0;
                        end
                    end
                    M_S1:
                    begin
                        sda_next = 1'b0;
                        st_next  = M_S2;
                    end
                    M_S2:
                    begin
                        scl_next = 1'b0;
                        st_next  = M_S3;
                    end
                    M_S3:
                    begin
                        act       = ACT_SEND;
                        send_byte = (step_reg == T_RDEV1) ? dev_reg + 8'd1 : dev_reg;
                    end
                    M_B1:
                    begin
                        scl_next = 1'b1;
                        st_next  = M_B2;
                    end
                    M_B2:
                    begin
                        scl_next = 1'b0;
                        if (bc_reg >= 4'd7)
                        begin
                            sda_next = 1'b1;
                        end
                        sb_next = {sb_reg[6:0], 1'b0};
                        st_next = M_B3;
                    end
                    M_B3:
                    begin
                        bc_next = bc_t;
                        if (bc_t < 4'd8)
                        begin
                            sda_next = sb_reg[7];
                            st_next  = M_B1;
                        end
                        else
                        begin
                            sda_next = 1'b1;
                            st_next  = M_A1;
                        end
                    end
                    M_A1:
                    begin
                        scl_next = 1'b1;
                        st_next  = M_A2;
                    end
                    M_A2:
                    begin
                        ack_next = !q_item.sda_in;
                        scl_next = 1'b0;
                        st_next  = M_A3;
                    end
                    M_A3:
                    begin
                        // Act on the acknowledge bit for the current step.
                        unique case (step_reg)
                            T_WDEV:
                            begin
                                if (ack_reg && cnt_reg != 5'd0)
                                begin
                                    step_next = T_WREG;
                                    act       = ACT_SEND;
                                    send_byte = rg_reg;
                                end
                                else
                                begin
                                    step_next = T_FINAL;
                                    fst_next  = 1'b1;
                                    act       = ACT_STOP;
                                end
                            end
                            T_WREG:
                            begin
                                if (ack_reg)
                                begin
                                    step_next = T_WDATA;
                                    bi_next   = '0;
                                    act       = ACT_SEND;
                                    send_byte = buf_mem[0];
                                end
                                else
                                begin
                                    step_next = T_FINAL;
                                    fst_next  = 1'b1;
                                    act       = ACT_STOP;
                                end
                            end
                            T_WDATA:
                            begin
                                if (!ack_reg)
                                begin
                                    step_next = T_FINAL;
                                    fst_next  = 1'b1;
                                    act       = ACT_STOP;
                                end
                                else
                                begin
                                    bi_next = bi_t[IDXW-1:0];
                                    if (bi_t < (IDXW + 1)'(cnt_reg) && bi_t < MAXV)
                                    begin
                                        act       = ACT_SEND;
                                        send_byte = buf_mem[bi_t[AW-1:0]];
                                    end
                                    else
                                    begin
                                        step_next = T_FINAL;
                                        fst_next  = 1'b0;
                                        act       = ACT_STOP;
                                    end
                                end
                            end
                            T_RDEV, T_RDEV1:
                            begin
                                if (ack_reg)
                                begin
                                    if (step_reg == T_RDEV)
                                    begin
                                        step_next = T_RREG;
                                        act       = ACT_SEND;
                                        send_byte = rg_reg;
                                    end
                                    else
                                    begin
                                        step_next = T_RDATA;
                                        bi_next   = '0;
                                        act       = ACT_RBYTE;
                                    end
                                end
                                else
                                begin
                                    ac_next = ac_t;
                                    if (ac_t >= cfg.retry_limit)
                                    begin
                                        step_next = T_FINAL;
                                        fst_next  = 1'b1;
                                        act       = ACT_STOP;
                                    end
                                    else
                                    begin
                                        act = ACT_START;
                                    end
                                end
                            end
                            T_RREG:
                            begin
                                act = ACT_STOP;
                                if (ack_reg)
                                begin
                                    step_next = T_MIDSTOP;
                                end
                                else
                                begin
                                    step_next = T_FINAL;
                                    fst_next  = 1'b1;
                                end
                            end
                            default:
                            begin
                                step_next = T_FINAL;
                                fst_next  = 1'b1;
                                act       = ACT_STOP;
                            end
                        endcase
                    end
                    M_R1:
                    begin
                        sb_next  = {sb_reg[6:0], q_item.sda_in};
                        scl_next = 1'b0;
                        st_next  = M_R2;
                    end
                    M_R2:
                    begin
                        bc_next = bc_t;
                        if (bc_t < 4'd8)
                        begin
                            act = ACT_RBIT;
                        end
                        else
                        begin
                            ev_rd    = 1'b1;
                            ev_data  = sb_reg;
                            ev_last  = is_last;
                            sda_next = is_last;
                            st_next  = M_K1;
                        end
                    end
                    M_K1:
                    begin
                        scl_next = 1'b1;
                        st_next  = M_K2;
                    end
                    M_K2:
                    begin
                        scl_next = 1'b0;
                        st_next  = M_K3;
                    end
                    M_K3:
                    begin
                        if (is_last)
                        begin
                            step_next = T_FINAL;
                            fst_next  = 1'b0;
                            act       = ACT_STOP;
                        end
                        else
                        begin
                            sda_next = 1'b1;
                            bi_next  = bi_t[IDXW-1:0];
                            act      = ACT_RBYTE;
                        end
                    end
                    default:
                    begin
                        st_next = M_IDLE;
                    end
                endcase
            end
        end

        // Apply the bus action that opens a new phase.
        unique case (act)
            ACT_STOP:
            begin
                sda_next = 1'b0;
                scl_next = 1'b1;
                st_next  = M_STOP;
            end
            ACT_START:
            begin
                sda_next = 1'b1;
                scl_next = 1'b1;
                st_next  = M_S1;
            end
            ACT_SEND:
            begin
                sb_next  = send_byte;
                bc_next  = 4'd0;
                sda_next = send_byte[7];
                st_next  = M_B1;
            end
            ACT_RBYTE:
            begin
                sb_next  = 8'd0;
                bc_next  = 4'd0;
                scl_next = 1'b1;
                st_next  = M_R1;
            end
            ACT_RBIT:
            begin
                scl_next = 1'b1;
                st_next  = M_R1;
            end
            default:
            begin
            end
        endcase
        if (act != ACT_NONE || st_next == M_IDLE)
        begin
            pc_next = 8'd0;
        end

        res_next.scl_out  = scl_next;
        res_next.sda_out  = sda_next;
        res_next.busy_res = (st_next != M_IDLE);
        res_next.rd_valid = ev_rd;
        res_next.rd_data  = ev_data;
        res_next.rd_last  = ev_rd && ev_last;
        res_next.done_res = ev_done;
        res_next.status   = ev_done && ev_status;
    end

    // Sequencer control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= M_IDLE;
            pc_reg        <= 8'd0;
            bc_reg        <= 4'd0;
            sb_reg        <= 8'd0;
            bi_reg        <= '0;
            ac_reg        <= 8'd0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            step_reg      <= T_PRESTOP;
            dev_reg       <= 8'd0;
            rg_reg        <= 8'd0;
            cnt_reg       <= 5'd0;
            fst_reg       <= 1'b0;
            ack_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                st_reg   <= st_next;
                pc_reg   <= pc_next;
                bc_reg   <= bc_next;
                sb_reg   <= sb_next;
                bi_reg   <= bi_next;
                ac_reg   <= ac_next;
                scl_reg  <= scl_next;
                sda_reg  <= sda_next;
                step_reg <= step_next;
                dev_reg  <= dev_next;
                rg_reg   <= rg_next;
                cnt_reg  <= cnt_next;
                fst_reg  <= fst_next;
                ack_reg  <= ack_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register and write byte buffer.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_res_reg <= res_next;
        end
        if (take && buf_we)
        begin
            buf_mem[buf_wa] <= q_item.wr_data;
        end
    end

`ifndef SYNTHESIS
    a_rd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.rd_valid |-> out_res_reg.busy_res)
        else $error("read byte reported outside a transaction");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.done_res |-> !out_res_reg.busy_res)
        else $error("transaction ended but still busy");
    a_bits: assert property (@(posedge clk) disable iff (!rst_n)
        bc_reg <= 4'd8)
        else $error("bit counter beyond one byte");
    a_idle_pc: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == M_IDLE |-> pc_reg == 8'd0)
        else $error("phase counter running while idle");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_i2c_register_transaction_master.sv
// Self-checking testbench for the I2C register transaction master.
`default_nettype none
module tb_i2c_register_transaction_master;
    import i2crtm_pkg::*;

    localparam int unsigned BUF_DEPTH = 16;
    localparam int unsigned CYCLE_LIMIT = 600000;

    // Bus sequencer steps and transaction phases of the predictor.
    typedef enum logic [4:0] {
        ST_IDLE, ST_STOP, ST_S1, ST_S2, ST_S3, ST_B1, ST_B2, ST_B3,
        ST_A1, ST_A2, ST_A3, ST_R1, ST_R2, ST_K1, ST_K2, ST_K3
    } bus_state_e;
    typedef enum logic [3:0] {
        TP_PRESTOP, TP_WDEV, TP_WREG, TP_WDATA, TP_RDEV, TP_RREG,
        TP_MIDSTOP, TP_RDEV1, TP_RDATA, TP_FINAL
    } txn_phase_e;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [7:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [4:0]  byte_count;
    logic [7:0]  wr_data;
    logic        sda_in;
    logic        out_valid;
    logic        out_ready;
    logic        scl_out;
    logic        sda_out;
    logic        busy_res;
    logic        rd_valid;
    logic [7:0]  rd_data;
    logic        rd_last;
    logic        done_res;
    logic        status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    i2c_register_transaction_master u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .dev_addr(dev_addr), .reg_addr(reg_addr),
        .byte_count(byte_count), .wr_data(wr_data), .sda_in(sda_in),
        .out_valid(out_valid), .out_ready(out_ready),
        .scl_out(scl_out), .sda_out(sda_out), .busy_res(busy_res),
        .rd_valid(rd_valid), .rd_data(rd_data), .rd_last(rd_last),
        .done_res(done_res), .status(status),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predicted bus master state.
    logic [7:0] m_retry, m_ticks;
    bus_state_e m_st;
    txn_phase_e m_phase;
    logic [7:0] m_pcnt, m_shift, m_attempt, m_dev, m_reg, m_fstat;
    logic [3:0] m_bit;
    logic [4:0] m_cnt;
    int         m_idx;
    logic [7:0] m_buf [BUF_DEPTH];
    logic       m_scl, m_sda, m_ack;
    logic       ev_rd, ev_last, ev_done, ev_stat;
    logic [7:0] ev_data;

    res_t       expected_results[$];
    int         filled_entries;
    bit         failed;
    int unsigned cycles;
    int         send_idle_pct, recv_stall_pct;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void go(bus_state_e s);
        m_st = s;
        m_pcnt = 8'd0;
    endfunction

    function automatic void start_stop();
        m_sda = 1'b0;
        m_scl = 1'b1;
        go(ST_STOP);
    endfunction

    function automatic void start_start();
        m_sda = 1'b1;
        m_scl = 1'b1;
        go(ST_S1);
    endfunction

    function automatic void send_byte(logic [7:0] b);
        m_shift = b;
        m_bit = 4'd0;
        m_sda = b[7];
        go(ST_B1);
    endfunction

    function automatic void read_bit();
        m_scl = 1'b1;
        go(ST_R1);
    endfunction

    function automatic void read_byte();
        m_shift = 8'd0;
        m_bit = 4'd0;
        read_bit();
    endfunction

    function automatic void end_with(logic st);
        m_phase = TP_FINAL;
        m_fstat = {7'd0, st};
        start_stop();
    endfunction

    function automatic bit last_read_byte();
        int n;
        n = (m_cnt == 5'd0) ? 1 : int'(m_cnt);
        return (m_idx + 1) >= n;
    endfunction

    function automatic void retry_or_fail();
        m_attempt = m_attempt + 8'd1;
        if (m_attempt >= m_retry)
            end_with(1'b1);
        else
            start_start();
    endfunction

    // Decision taken after the acknowledge bit of a sent byte.
    function automatic void after_ack(logic ok);
        int wcount;
        wcount = (m_cnt > BUF_DEPTH) ? BUF_DEPTH : int'(m_cnt);
        case (m_phase)
            TP_WDEV:
                if (ok && m_cnt != 5'd0)
                begin
                    m_phase = TP_WREG;
                    send_byte(m_reg);
                end
                else
                    end_with(1'b1);
            TP_WREG:
                if (ok)
                begin
                    m_phase = TP_WDATA;
                    m_idx = 0;
                    send_byte(m_buf[0]);
                end
                else
                    end_with(1'b1);
            TP_WDATA:
                if (!ok)
                    end_with(1'b1);
                else
                begin
                    m_idx++;
                    if (m_idx < wcount)
                        send_byte(m_buf[m_idx]);
                    else
                        end_with(1'b0);
                end
            TP_RDEV:
                if (ok)
                begin
                    m_phase = TP_RREG;
                    send_byte(m_reg);
                end
                else
                    retry_or_fail();
            TP_RREG:
                if (ok)
                begin
                    m_phase = TP_MIDSTOP;
                    start_stop();
                end
                else
                    end_with(1'b1);
            TP_RDEV1:
                if (ok)
                begin
                    m_phase = TP_RDATA;
                    m_idx = 0;
                    read_byte();
                end
                else
                    retry_or_fail();
            default:
                end_with(1'b1);
        endcase
    endfunction

    function automatic void stop_done();
        if (m_phase == TP_PRESTOP)
        begin
            m_phase = TP_WDEV;
            start_start();
        end
        else if (m_phase == TP_MIDSTOP)
        begin
            m_phase = TP_RDEV1;
            m_attempt = 8'd0;
            start_start();
        end
        else
        begin
            go(ST_IDLE);
            ev_done = 1'b1;
            ev_stat = m_fstat[0];
            m_idx = 0;
        end
    endfunction

    // One bus step, taken when a delay phase runs out.
    function automatic void bus_advance(logic line);
        case (m_st)
            ST_STOP:
            begin
                m_sda = 1'b1;
                stop_done();
            end
            ST_S1:
            begin
                m_sda = 1'b0;
                go(ST_S2);
            end
            ST_S2:
            begin
                m_scl = 1'b0;
                go(ST_S3);
            end
            ST_S3:
                send_byte(m_phase == TP_RDEV1 ? m_dev + 8'd1 : m_dev);
            ST_B1:
            begin
                m_scl = 1'b1;
                go(ST_B2);
            end
            ST_B2:
            begin
                m_scl = 1'b0;
                if (m_bit >= 4'd7)
                    m_sda = 1'b1;
                m_shift = m_shift << 1;
                go(ST_B3);
            end
            ST_B3:
            begin
                m_bit = m_bit + 4'd1;
                if (m_bit < 4'd8)
                begin
                    m_sda = m_shift[7];
                    go(ST_B1);
                end
                else
                begin
                    m_sda = 1'b1;
                    go(ST_A1);
                end
            end
            ST_A1:
            begin
                m_scl = 1'b1;
                go(ST_A2);
            end
            ST_A2:
            begin
                m_ack = (line == 1'b0);
                m_scl = 1'b0;
                go(ST_A3);
            end
            ST_A3:
                after_ack(m_ack);
            ST_R1:
            begin
                m_shift = {m_shift[6:0], line};
                m_scl = 1'b0;
                go(ST_R2);
            end
            ST_R2:
            begin
                m_bit = m_bit + 4'd1;
                if (m_bit < 4'd8)
                    read_bit();
                else
                begin
                    ev_rd = 1'b1;
                    ev_data = m_shift;
                    ev_last = last_read_byte();
                    m_sda = ev_last;
                    go(ST_K1);
                end
            end
            ST_K1:
            begin
                m_scl = 1'b1;
                go(ST_K2);
            end
            ST_K2:
            begin
                m_scl = 1'b0;
                go(ST_K3);
            end
            ST_K3:
                if (last_read_byte())
                    end_with(1'b0);
                else
                begin
                    m_sda = 1'b1;
                    m_idx++;
                    read_byte();
                end
            default:
                go(ST_IDLE);
        endcase
    endfunction

    // Works out the result of one accepted request and updates the state.
    function automatic res_t predict_bus_result(item_t it);
        res_t r;
        logic [7:0] lim;
        ev_rd = 1'b0;
        ev_last = 1'b0;
        ev_done = 1'b0;
        ev_data = 8'd0;
        ev_stat = 1'b0;
        lim = (m_ticks == 8'd0) ? 8'd1 : m_ticks;
        if (m_st == ST_IDLE)
        begin
            if (it.req_type == REQ_PUSH)
            begin
                if (m_idx < BUF_DEPTH)
                begin
                    m_buf[m_idx] = it.wr_data;
                    m_idx++;
                end
            end
            else if (it.req_type == REQ_WRITE || it.req_type == REQ_READ)
            begin
                m_dev = it.dev_addr;
                m_reg = it.reg_addr;
                m_cnt = it.byte_count;
                m_idx = 0;
                m_attempt = 8'd0;
                m_fstat = 8'd0;
                if (it.req_type == REQ_WRITE)
                begin
                    m_phase = TP_PRESTOP;
                    start_stop();
                end
                else
                begin
                    m_phase = TP_RDEV;
                    start_start();
                end
            end
        end
        else if (it.req_type == REQ_TICK)
        begin
            m_pcnt = m_pcnt + 8'd1;
            if (m_pcnt >= lim)
            begin
                m_pcnt = 8'd0;
                bus_advance(it.sda_in);
            end
        end
        r.scl_out = m_scl;
        r.sda_out = m_sda;
        r.busy_res = (m_st != ST_IDLE);
        r.rd_valid = ev_rd;
        r.rd_data = ev_rd ? ev_data : 8'd0;
        r.rd_last = ev_rd & ev_last;
        r.done_res = ev_done;
        r.status = ev_done & ev_stat;
        return r;
    endfunction

    // Offers one request, waits for its acceptance, and records the expected result.
    task automatic send_request(item_t it, bit typed, res_t typed_res);
        res_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        req_type <= it.req_type;
        dev_addr <= it.dev_addr;
        reg_addr <= it.reg_addr;
        byte_count <= it.byte_count;
        wr_data <= it.wr_data;
        sda_in <= it.sda_in;
        do
            @(posedge clk);
        while (!in_ready);
        r = predict_bus_result(it);
        if (m_st == ST_IDLE && it.req_type == REQ_PUSH && m_idx > filled_entries)
            filled_entries = m_idx;
        expected_results.push_back(typed ? typed_res : r);
    endtask

    function automatic item_t random_fields();
        item_t it;
        it.req_type = 2'($urandom_range(3));
        it.dev_addr = 8'($urandom);
        it.reg_addr = 8'($urandom);
        it.byte_count = 5'($urandom);
        it.wr_data = 8'($urandom);
        it.sda_in = 1'($urandom_range(1));
        return it;
    endfunction

    // Ticks the bus until the transaction ends, mixing in other requests at
    // noise_pct; the device answers the acknowledge slots with a NACK at nack_pct.
    task automatic drive_bus_to_idle(int nack_pct, int noise_pct);
        item_t it;
        res_t none;
        none = '0;
        while (m_st != ST_IDLE)
        begin
            it = random_fields();
            if ($urandom_range(99) >= noise_pct)
                it.req_type = REQ_TICK;
            if (m_st == ST_A2)
                it.sda_in = ($urandom_range(99) < nack_pct);
            send_request(it, 1'b0, none);
        end
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Waits until every result is in and the block has settled.
    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic apb_write(logic idx, logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_RETRY_LIMIT)
            m_retry = value;
        else
            m_ticks = value;
    endtask

    // One random transaction: pushes, stray idle ticks, a start, then the bus run.
    task automatic random_transaction(bit short_only);
        item_t it;
        res_t none;
        int pushes, wcount, nack_pct;
        none = '0;
        pushes = ($urandom_range(3) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 4);
        if (short_only)
            pushes = 1;
        repeat (pushes)
        begin
            it = random_fields();
            it.req_type = REQ_PUSH;
            send_request(it, 1'b0, none);
        end
        // Up to two stray ticks while idle.
        repeat ($urandom_range(0, 2))
        begin
            it = random_fields();
            it.req_type = REQ_TICK;
            send_request(it, 1'b0, none);
        end
        it = random_fields();
        it.req_type = $urandom_range(1) ? REQ_WRITE : REQ_READ;
        if (short_only)
        begin
            it.req_type = REQ_WRITE;
            it.byte_count = 5'd0;
        end
        else if (it.req_type == REQ_READ && $urandom_range(4) != 0)
            it.byte_count = 5'($urandom_range(0, 3));
        else if (it.req_type == REQ_WRITE)
        begin
            wcount = (it.byte_count > BUF_DEPTH) ? BUF_DEPTH : int'(it.byte_count);
            if (wcount > filled_entries)
                it.byte_count = 5'(filled_entries);
        end
        nack_pct = ($urandom_range(3) == 0) ? 40 : 3;
        send_request(it, 1'b0, none);
        drive_bus_to_idle(nack_pct, short_only ? 0 : 8);
    endtask

    // Directed rows: request, whether the result is typed in, the result,
    // and the NACK rate for the transaction that follows.
    typedef struct {
        item_t it;
        bit    typed;
        res_t  res;
        int    nack_pct;
    } directed_row_t;

    directed_row_t directed_rows[] = '{
        // Tick while idle leaves both lines released.
        '{'{REQ_TICK, 8'h00, 8'h00, 5'd0, 8'h00, 1'b0}, 1'b1, '{1,1,0,0,8'h00,0,0,0}, 0},
        '{'{REQ_PUSH, 8'hFF, 8'hFF, 5'd31, 8'h00, 1'b1}, 1'b0, '0, 0},
        '{'{REQ_PUSH, 8'h00, 8'h00, 5'd0, 8'hFF, 1'b0}, 1'b0, '0, 0},
        '{'{REQ_PUSH, 8'h12, 8'h34, 5'd5, 8'h5A, 1'b1}, 1'b0, '0, 0},
        // Write opens with a stop: SCL high, SDA low.
        '{'{REQ_WRITE, 8'hFE, 8'hFF, 5'd3, 8'h00, 1'b0}, 1'b1, '{1,0,1,0,8'h00,0,0,0}, 0},
        // Zero-length write fails after the address.
        '{'{REQ_WRITE, 8'h00, 8'h00, 5'd0, 8'hFF, 1'b1}, 1'b0, '0, 0},
        // Read opens with a start: both lines released.
        '{'{REQ_READ, 8'hFF, 8'h80, 5'd0, 8'h00, 1'b0}, 1'b1, '{1,1,1,0,8'h00,0,0,0}, 0},
        '{'{REQ_READ, 8'h02, 8'h7F, 5'd31, 8'hAA, 1'b1}, 1'b0, '0, 0},
        '{'{REQ_WRITE, 8'h10, 8'h20, 5'd2, 8'h00, 1'b0}, 1'b0, '0, 100},
        '{'{REQ_READ, 8'hA0, 8'h01, 5'd1, 8'h00, 1'b0}, 1'b0, '0, 100},
        '{'{REQ_READ, 8'h54, 8'h0F, 5'd2, 8'h00, 1'b1}, 1'b0, '0, 50}
    };

    // Configuration settings per phase: retry_limit, phase_ticks.
    logic [7:0] phase_retry[6] = '{8'd20, 8'd1, 8'd255, 8'd0, 8'd3, 8'd255};
    logic [7:0] phase_tick[6] = '{8'd1, 8'd1, 8'd2, 8'd0, 8'd1, 8'd255};

    // Stimulus and end of run.
    initial
    begin
        int sent_target;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_TICK;
        dev_addr = 8'd0;
        reg_addr = 8'd0;
        byte_count = 5'd0;
        wr_data = 8'd0;
        sda_in = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 3'd0;
        pwdata = 32'd0;
        m_retry = RETRY_LIMIT_RST;
        m_ticks = PHASE_TICKS_RST;
        m_st = ST_IDLE;
        m_phase = TP_PRESTOP;
        m_pcnt = 8'd0;
        m_shift = 8'd0;
        m_attempt = 8'd0;
        m_dev = 8'd0;
        m_reg = 8'd0;
        m_fstat = 8'd0;
        m_bit = 4'd0;
        m_cnt = 5'd0;
        m_idx = 0;
        m_scl = 1'b1;
        m_sda = 1'b1;
        m_ack = 1'b0;
        filled_entries = 0;
        failed = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].it, directed_rows[i].typed,
                directed_rows[i].res);
            drive_bus_to_idle(directed_rows[i].nack_pct, 0);
        end
        release_input();
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            apb_write(REG_RETRY_LIMIT, phase_retry[p]);
            apb_write(REG_PHASE_TICKS, phase_tick[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 46;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 46;
                end
                default:
                begin
                    send_idle_pct = 10;
                    recv_stall_pct = 10;
                end
            endcase
            if (p == 5)
                random_transaction(1'b1);
            else
            begin
                sent_target = 130;
                while (sent_target > 0)
                begin
                    random_transaction(1'b0);
                    sent_target -= 30;
                end
            end
            release_input();
            wait_drained();
        end

        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result checking, cycle limit and receiver stalls.
    always @(posedge clk)
    begin
        res_t want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request pending");
                    failed = 1'b1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (scl_out !== want.scl_out)
                    begin
                        $error("scl_out expected %0h actual %0h", want.scl_out, scl_out);
                        failed = 1'b1;
                    end
                    if (sda_out !== want.sda_out)
                    begin
                        $error("sda_out expected %0h actual %0h", want.sda_out, sda_out);
                        failed = 1'b1;
                    end
                    if (busy_res !== want.busy_res)
                    begin
                        $error("busy_res expected %0h actual %0h", want.busy_res, busy_res);
                        failed = 1'b1;
                    end
                    if (rd_valid !== want.rd_valid)
                    begin
                        $error("rd_valid expected %0h actual %0h", want.rd_valid, rd_valid);
                        failed = 1'b1;
                    end
                    if (rd_data !== want.rd_data)
                    begin
                        $error("rd_data expected %0h actual %0h", want.rd_data, rd_data);
                        failed = 1'b1;
                    end
                    if (rd_last !== want.rd_last)
                    begin
                        $error("rd_last expected %0h actual %0h", want.rd_last, rd_last);
                        failed = 1'b1;
                    end
                    if (done_res !== want.done_res)
                    begin
                        $error("done_res expected %0h actual %0h", want.done_res, done_res);
                        failed = 1'b1;
                    end
                    if (status !== want.status)
                    begin
                        $error("status expected %0h actual %0h", want.status, status);
                        failed = 1'b1;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        cycles = 0;
        out_ready = 1'b0;
    end

endmodule
`default_nettype wire
